@@ sv/vtn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_pkg
// Shared constants, payload words and matrix bundles for the vertex
// transform and normal normalization pipeline.
// ----------------------------------------------------------------------------
package vtn_pkg;

    localparam int POS_WORDS       = 256;
    localparam int NRM_WORDS       = 96;
    localparam int ROWS            = 3;
    localparam int POS_ROW_W       = 4;
    localparam int NRM_ROW_W       = 3;
    localparam int POS_GROUPS      = POS_WORDS / POS_ROW_W;
    localparam int NRM_GROUPS      = NRM_WORDS / NRM_ROW_W;
    localparam int POS_GW          = $clog2(POS_GROUPS);
    localparam int NRM_GW          = $clog2(NRM_GROUPS);

    localparam int MAX_POS_SLOT    = 61;
    localparam int MAX_NRM_SLOT    = 29;
    localparam int NRM_SLOT_OFFSET = 32;

    localparam int SUM_W           = 49;
    localparam int SQRT_STEPS      = 32;
    localparam int DIV_STEPS       = 15;
    localparam int NRM_LAT         = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [1:0]  CFG_NORMALS  = 2'd0;
    localparam logic [1:0]  CFG_COLOR    = 2'd1;
    localparam logic [1:0]  CFG_TEXCOORD = 2'd2;
    localparam logic [31:0] COLOR_WHITE  = 32'hFFFF_FFFF;

    typedef logic [2:0][31:0]        t_vec3;
    typedef logic [2:0][3:0][31:0]   t_pos_rows;
    typedef logic [2:0][2:0][31:0]   t_nrm_rows;
    typedef logic [2:0][SUM_W-1:0]   t_sum3;
    typedef logic [2:0][15:0]        t_unit3;

    typedef struct packed {
        logic               kind;
        logic [8:0]         slot_or_address;
        logic signed [31:0] word_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [31:0]        color_rgba;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_nx;
        logic signed [15:0] out_ny;
        logic signed [15:0] out_nz;
        logic [31:0]        out_color;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic               ok;
    } t_out;

endpackage

@@ sv/vtn_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_store
// Banked position and normal matrix memories. Each bank holds one column
// and is copied once per row so a whole 3x4 and 3x3 matrix are read together.
// ----------------------------------------------------------------------------
module vtn_store (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_we,
    input  logic [8:0]                i_waddr,
    input  logic [31:0]               i_wdata,
    input  logic [vtn_pkg::POS_GW-1:0] i_pos_base,
    input  logic [vtn_pkg::NRM_GW-1:0] i_nrm_base,
    output vtn_pkg::t_pos_rows        o_pos,
    output vtn_pkg::t_nrm_rows        o_nrm
);
    import vtn_pkg::*;

    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;

    logic              w_pos_we;
    logic [1:0]        w_pos_col;
    logic [POS_GW-1:0] w_pos_grp;
    logic [8:0]        w_noff;
    logic              w_nrm_we;
    logic [6:0]        w_na;
    logic [15:0]       w_nprod;
    logic [NRM_GW-1:0] w_nrm_grp;
    logic [6:0]        w_ng3;
    logic [6:0]        w_ncol7;
    logic [1:0]        w_nrm_col;

    assign w_pos_we  = i_we && (i_waddr < 9'(POS_WORDS));
    assign w_pos_col = i_waddr[1:0];
    assign w_pos_grp = i_waddr[POS_GW+1:2];

    // divide the normal word offset by three with a reciprocal
    assign w_noff    = i_waddr - 9'(POS_WORDS);
    assign w_nrm_we  = i_we && (i_waddr >= 9'(POS_WORDS)) && (w_noff < 9'(NRM_WORDS));
    assign w_na      = w_noff[6:0];
    assign w_nprod   = 16'(w_na) * 16'(DIV3_MUL);
    assign w_nrm_grp = w_nprod[DIV3_SHIFT+NRM_GW-1:DIV3_SHIFT];
    assign w_ng3     = 7'({w_nrm_grp, 1'b0}) + 7'(w_nrm_grp);
    assign w_ncol7   = w_na - w_ng3;
    assign w_nrm_col = w_ncol7[1:0];

    for (genvar c = 0; c < POS_ROW_W; c++) begin : g_pcol
        for (genvar i = 0; i < ROWS; i++) begin : g_prow
            logic [31:0] r_mem [POS_GROUPS];
            logic [31:0] r_q;
            always_ff @(posedge i_clk) begin
                if (w_pos_we && w_pos_col == 2'(c)) begin
                    r_mem[w_pos_grp] <= i_wdata;
                end
                if (i_en) begin
                    r_q <= r_mem[i_pos_base + POS_GW'(i)];
                end
            end
            assign o_pos[i][c] = r_q;
        end
    end

    for (genvar c = 0; c < NRM_ROW_W; c++) begin : g_ncol
        for (genvar i = 0; i < ROWS; i++) begin : g_nrow
            logic [31:0] r_mem [NRM_GROUPS];
            logic [31:0] r_q;
            always_ff @(posedge i_clk) begin
                if (w_nrm_we && w_nrm_col == 2'(c)) begin
                    r_mem[w_nrm_grp] <= i_wdata;
                end
                if (i_en) begin
                    r_q <= r_mem[i_nrm_base + NRM_GW'(i)];
                end
            end
            assign o_nrm[i][c] = r_q;
        end
    end

endmodule

@@ sv/vtn_xform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_xform
// Matrix multiply: exact products, floor-reduced row sums, then the
// translation add with saturation for the position.
// ----------------------------------------------------------------------------
module vtn_xform (
    input  logic               i_clk,
    input  logic               i_en,
    input  vtn_pkg::t_pos_rows i_pos_rows,
    input  vtn_pkg::t_nrm_rows i_nrm_rows,
    input  vtn_pkg::t_vec3     i_pos,
    input  vtn_pkg::t_vec3     i_nrm,
    output vtn_pkg::t_vec3     o_pos,
    output logic               o_ovf,
    output vtn_pkg::t_sum3     o_nsum
);
    import vtn_pkg::*;

    logic signed [63:0]      r_pp [3][3];
    logic signed [63:0]      r_np [3][3];
    logic signed [31:0]      r_tr2 [3];
    logic signed [31:0]      r_tr3 [3];
    logic signed [SUM_W-1:0] r_ps [3];
    logic signed [SUM_W-1:0] r_ns [3];
    logic signed [64:0]      w_psum [3];
    logic signed [64:0]      w_nsum [3];
    logic signed [SUM_W:0]   w_v [3];
    logic [2:0]              w_ovf;
    t_vec3                   n_pos;
    t_vec3                   r_pos;
    logic                    r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= $signed(i_pos_rows[i][j]) * $signed(i_pos[j]);
                    r_np[i][j] <= $signed(i_nrm_rows[i][j]) * $signed(i_nrm[j]);
                end
                r_tr2[i] <= $signed(i_pos_rows[i][3]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_psum[i] = 65'(r_pp[i][0]) + 65'(r_pp[i][1]) + 65'(r_pp[i][2]);
            w_nsum[i] = 65'(r_np[i][0]) + 65'(r_np[i][1]) + 65'(r_np[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ps[i]  <= w_psum[i][64:16];
                r_ns[i]  <= w_nsum[i][64:16];
                r_tr3[i] <= r_tr2[i];
            end
        end
    end

    // translation add and saturation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]   = (SUM_W+1)'(r_ps[i]) + (SUM_W+1)'(r_tr3[i]);
            w_ovf[i] = !((&w_v[i][SUM_W:31]) || !(|w_v[i][SUM_W:31]));
            if (!w_ovf[i]) begin
                n_pos[i] = w_v[i][31:0];
            end else if (w_v[i][SUM_W]) begin
                n_pos[i] = 32'h8000_0000;
            end else begin
                n_pos[i] = 32'h7FFF_FFFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= n_pos;
            r_ovf <= |w_ovf;
        end
    end

    assign o_pos = r_pos;
    assign o_ovf = r_ovf;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_nsum[i] = r_ns[i];
        end
    end

endmodule

@@ sv/vtn_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtn_norm
// Normal normalization: magnitude, power-of-two scaling, sum of squares,
// bit-serial square root and three pipelined rounding dividers.
// ----------------------------------------------------------------------------
module vtn_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  vtn_pkg::t_sum3 i_n,
    output vtn_pkg::t_unit3 o_unit
);
    import vtn_pkg::*;

    localparam int GRP_W      = 7;
    localparam int N_GRP      = SUM_W / GRP_W;
    localparam int MSB_TARGET = 30;
    localparam int M_W        = MSB_TARGET + 1;
    localparam int REM_W      = 36;
    localparam int DREM_W     = 47;

    typedef struct packed {
        logic [63:0]           x;
        logic [REM_W-1:0]      rem;
        logic [31:0]           root;
        logic [2:0][M_W-1:0]   mag;
        logic [2:0]            sg;
        logic                  zero;
    } t_sq;

    typedef struct packed {
        logic [2:0][DREM_W-1:0] rem;
        logic [2:0][DIV_STEPS-1:0] q;
        logic [31:0]           r;
        logic [2:0]            sg;
        logic                  zero;
    } t_dv;

    function automatic logic [2:0] msb7(input logic [GRP_W-1:0] v);
        logic [2:0] p;
        p = '0;
        for (int b = 0; b < GRP_W; b++) begin
            if (v[b]) begin
                p = 3'(b);
            end
        end
        return p;
    endfunction

    function automatic t_sq sq_step(input t_sq s);
        t_sq        n;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        n     = s;
        rem2  = {s.rem[REM_W-3:0], s.x[63:62]};
        trial = {2'b00, s.root, 2'b01};
        if (rem2 >= trial) begin
            n.rem  = rem2 - trial;
            n.root = {s.root[30:0], 1'b1};
        end else begin
            n.rem  = rem2;
            n.root = {s.root[30:0], 1'b0};
        end
        n.x = {s.x[61:0], 2'b00};
        return n;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic [3:0] b);
        t_dv              n;
        logic [DREM_W-1:0] d;
        n = s;
        d = DREM_W'(s.r) << b;
        for (int i = 0; i < 3; i++) begin
            if (s.rem[i] >= d) begin
                n.rem[i] = s.rem[i] - d;
                n.q[i]   = {s.q[i][DIV_STEPS-2:0], 1'b1};
            end else begin
                n.q[i]   = {s.q[i][DIV_STEPS-2:0], 1'b0};
            end
        end
        return n;
    endfunction

    logic [2:0][SUM_W-1:0]  r_mag1;
    logic [2:0]             r_sg1;
    logic [2:0][SUM_W-1:0]  r_mag2;
    logic [2:0]             r_sg2;
    logic [N_GRP-1:0]       r_gnz;
    logic [2:0]             r_gpos [N_GRP];
    logic [SUM_W-1:0]       w_or;
    logic [2:0][SUM_W-1:0]  r_mag3;
    logic [2:0]             r_sg3;
    logic [5:0]             r_lead;
    logic                   r_zero3;
    logic [5:0]             w_lead;
    logic [2:0][M_W-1:0]    r_m4;
    logic [2:0]             r_sg4;
    logic                   r_zero4;
    logic [2:0][M_W-1:0]    w_m4;
    logic [2:0][2*M_W-1:0]  r_sqr;
    logic [2:0][M_W-1:0]    r_m5;
    logic [2:0]             r_sg5;
    logic                   r_zero5;
    t_sq                    w_sq0;
    t_sq                    r_sq [SQRT_STEPS];
    t_dv                    w_dv0;
    t_dv                    r_dv [DIV_STEPS+1];
    t_dv                    w_dvl;
    t_unit3                 r_unit;

    // magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sg1[i]  <= i_n[i][SUM_W-1];
                r_mag1[i] <= i_n[i][SUM_W-1] ? (SUM_W'(0) - i_n[i]) : i_n[i];
            end
        end
    end

    // leading one, first level
    assign w_or = r_mag1[0] | r_mag1[1] | r_mag1[2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag2 <= r_mag1;
            r_sg2  <= r_sg1;
            for (int g = 0; g < N_GRP; g++) begin
                r_gnz[g]  <= |w_or[g*GRP_W +: GRP_W];
                r_gpos[g] <= msb7(w_or[g*GRP_W +: GRP_W]);
            end
        end
    end

    // leading one, second level
    always_comb begin
        w_lead = '0;
        for (int g = 0; g < N_GRP; g++) begin
            if (r_gnz[g]) begin
                w_lead = 6'(g * GRP_W) + 6'(r_gpos[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag3  <= r_mag2;
            r_sg3   <= r_sg2;
            r_lead  <= w_lead;
            r_zero3 <= ~|r_gnz;
        end
    end

    // scale so the largest magnitude sits in [2^30, 2^31)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_lead > 6'(MSB_TARGET)) begin
                w_m4[i] = M_W'(r_mag3[i] >> (r_lead - 6'(MSB_TARGET)));
            end else begin
                w_m4[i] = M_W'(r_mag3[i] << (6'(MSB_TARGET) - r_lead));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m4    <= w_m4;
            r_sg4   <= r_sg3;
            r_zero4 <= r_zero3;
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= (2*M_W)'(r_m4[i]) * (2*M_W)'(r_m4[i]);
            end
            r_m5    <= r_m4;
            r_sg5   <= r_sg4;
            r_zero5 <= r_zero4;
        end
    end

    always_comb begin
        w_sq0      = '0;
        w_sq0.x    = 64'(r_sqr[0]) + 64'(r_sqr[1]) + 64'(r_sqr[2]);
        w_sq0.mag  = r_m5;
        w_sq0.sg   = r_sg5;
        w_sq0.zero = r_zero5;
    end

    // sum of squares registered as the first root step input
    t_sq r_sq_in;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_in  <= w_sq0;
            r_sq[0]  <= sq_step(r_sq_in);
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq[k] <= sq_step(r_sq[k-1]);
            end
        end
    end

    // rounding dividend
    always_comb begin
        w_dv0      = '0;
        w_dv0.r    = r_sq[SQRT_STEPS-1].root;
        w_dv0.sg   = r_sq[SQRT_STEPS-1].sg;
        w_dv0.zero = r_sq[SQRT_STEPS-1].zero;
        for (int i = 0; i < 3; i++) begin
            w_dv0.rem[i] = DREM_W'({r_sq[SQRT_STEPS-1].mag[i], 14'b0})
                         + DREM_W'(r_sq[SQRT_STEPS-1].root[31:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= w_dv0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv[k] <= dv_step(r_dv[k-1], 4'(DIV_STEPS - k));
            end
        end
    end

    assign w_dvl = r_dv[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_dvl.zero) begin
                    r_unit[i] <= '0;
                end else if (w_dvl.sg[i]) begin
                    r_unit[i] <= 16'(0) - 16'(w_dvl.q[i]);
                end else begin
                    r_unit[i] <= 16'(w_dvl.q[i]);
                end
            end
        end
    end

    assign o_unit = r_unit;

endmodule

@@ sv/vertex_transform_normalize.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_normalize
// Vertex transform with matrix stores, normal normalization and output skid.
//
// Input channel i_in_valid/o_in_ready carries one t_in word. A kind 0 word
// writes one matrix word at its accept edge if its address is below 352
// and gives no result; a kind 1 word is a vertex and gives exactly one t_out
// word on o_out_valid/i_out_ready, in order. A vertex may follow a load in the next cycle.
// Configuration: i_cfg_we writes register i_cfg_addr (0 normals, 1 color,
// 2 texcoord) with i_cfg_wdata. The user must write it only while no vertex
// is in flight; the block does not enforce this. Throughput: one word per
// cycle while o_in_ready is high. The normal path, with its 32-step square
// root and 15-step dividers, is the longer one; the position path is delayed to match.
// Reset clears the configuration to zero and drops every word in flight;
// matrix words keep no reset value and must be loaded before use.
// When the receiver stalls, a two-word output buffer holds results; once
// it is full o_in_ready drops and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module vertex_transform_normalize (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vtn_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output vtn_pkg::t_out   o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_addr,
    input  logic            i_cfg_wdata
);
    import vtn_pkg::*;

    localparam int SIDE_LEN = NRM_LAT + 3;
    localparam int POS_DLY  = NRM_LAT - 1;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [31:0] color;
        logic [31:0] u;
        logic [31:0] v;
    } t_side;

    typedef struct packed {
        t_vec3 p;
        logic  ovf;
    } t_pres;

    logic       r_cfg_nrm;
    logic       r_cfg_col;
    logic       r_cfg_tex;
    logic       w_en;
    logic       w_acc;
    logic       w_vtx;
    logic       w_load;
    logic [8:0] w_slot;
    logic [8:0] w_ns;
    logic       w_bad;
    t_side      r_side [SIDE_LEN];
    t_vec3      r_s1_pos;
    t_vec3      r_s1_nrm;
    t_pos_rows  w_pos_rows;
    t_nrm_rows  w_nrm_rows;
    t_vec3      w_xpos;
    logic       w_xovf;
    t_sum3      w_nsum;
    t_unit3     w_unit;
    t_pres      r_pd [POS_DLY];
    t_side      w_f;
    t_pres      w_p;
    t_out       w_res;
    logic       r_out_valid;
    logic       r_skid_valid;
    t_out       r_out_data;
    t_out       r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nrm <= 1'b0;
            r_cfg_col <= 1'b0;
            r_cfg_tex <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NORMALS:  r_cfg_nrm <= i_cfg_wdata;
                CFG_COLOR:    r_cfg_col <= i_cfg_wdata;
                CFG_TEXCOORD: r_cfg_tex <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;
    assign w_vtx      = w_acc && i_in_data.kind;
    assign w_load     = w_acc && !i_in_data.kind;

    // slot checks
    assign w_slot = i_in_data.slot_or_address;
    assign w_ns   = (w_slot >= 9'(NRM_SLOT_OFFSET)) ? (w_slot - 9'(NRM_SLOT_OFFSET)) : w_slot;
    assign w_bad  = (w_slot > 9'(MAX_POS_SLOT)) || (r_cfg_nrm && (w_ns > 9'(MAX_NRM_SLOT)));

    vtn_store u_store (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_we       (w_load),
        .i_waddr    (w_slot),
        .i_wdata    (i_in_data.word_value),
        .i_pos_base (w_slot[POS_GW-1:0]),
        .i_nrm_base (w_ns[NRM_GW-1:0]),
        .o_pos      (w_pos_rows),
        .o_nrm      (w_nrm_rows)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_LEN; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0].valid <= w_vtx;
            r_side[0].bad   <= w_bad;
            r_side[0].color <= i_in_data.color_rgba;
            r_side[0].u     <= i_in_data.tex_u;
            r_side[0].v     <= i_in_data.tex_v;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pos <= {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
            r_s1_nrm <= {i_in_data.nrm_z, i_in_data.nrm_y, i_in_data.nrm_x};
        end
    end

    vtn_xform u_xform (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_pos_rows (w_pos_rows),
        .i_nrm_rows (w_nrm_rows),
        .i_pos      (r_s1_pos),
        .i_nrm      (r_s1_nrm),
        .o_pos      (w_xpos),
        .o_ovf      (w_xovf),
        .o_nsum     (w_nsum)
    );

    vtn_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (w_nsum),
        .o_unit (w_unit)
    );

    // position waits for the normal path
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0].p   <= w_xpos;
            r_pd[0].ovf <= w_xovf;
            for (int k = 1; k < POS_DLY; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    assign w_f = r_side[SIDE_LEN-1];
    assign w_p = r_pd[POS_DLY-1];

    always_comb begin
        w_res = '0;
        if (!w_f.bad) begin
            w_res.out_x     = w_p.p[0];
            w_res.out_y     = w_p.p[1];
            w_res.out_z     = w_p.p[2];
            w_res.out_nx    = r_cfg_nrm ? w_unit[0] : 16'd0;
            w_res.out_ny    = r_cfg_nrm ? w_unit[1] : 16'd0;
            w_res.out_nz    = r_cfg_nrm ? w_unit[2] : 16'd0;
            w_res.out_color = r_cfg_col ? w_f.color : COLOR_WHITE;
            w_res.out_u     = r_cfg_tex ? w_f.u : 32'd0;
            w_res.out_v     = r_cfg_tex ? w_f.v : 32'd0;
            w_res.ok        = !w_p.ovf;
        end
    end

    // output word and skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (w_en && w_f.valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= w_f.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (w_en && w_f.valid) begin
                r_skid_data <= w_res;
            end
        end else if (r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word present right after reset");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_data.out_nx) <= 16'sd16384
            && $signed(o_out_data.out_nx) >= -16'sd16384
            && $signed(o_out_data.out_ny) <= 16'sd16384
            && $signed(o_out_data.out_ny) >= -16'sd16384
            && $signed(o_out_data.out_nz) <= 16'sd16384
            && $signed(o_out_data.out_nz) >= -16'sd16384))
        else $error("unit normal component out of range");

    a_nrm_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_f.valid && !r_cfg_nrm) |->
            (w_res.out_nx == 16'd0 && w_res.out_ny == 16'd0 && w_res.out_nz == 16'd0))
        else $error("normal present while normals are off");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for vertex_transform_normalize. It fills both matrix stores, then
// runs directed and random load and vertex words under every configuration.
// Idle gaps and output stalls are random. A scoreboard class models the
// matrix stores, the fixed-point transform and the normalization, and checks
// each result word in order against its own prediction.
// ----------------------------------------------------------------------------
module tb;
    import vtn_pkg::*;

    class vertex_scoreboard;
        logic [31:0] pos_mem [POS_WORDS];
        logic [31:0] nrm_mem [NRM_WORDS];
        bit          nrm_en, col_en, tex_en;
        t_out        expected_q [$];
        int          mismatches;

        function void set_cfg(logic [1:0] idx, bit val);
            if (idx == CFG_NORMALS) nrm_en = val;
            else if (idx == CFG_COLOR) col_en = val;
            else if (idx == CFG_TEXCOORD) tex_en = val;
        endfunction

        function void add_expected(t_out o);
            expected_q = {expected_q, o};
        endfunction

        function logic signed [65:0] dot_floor(logic [31:0] m0, logic [31:0] m1,
                                               logic [31:0] m2, logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               logic signed [31:0] c);
            longint p0, p1, p2;
            logic signed [65:0] e0, e1, e2;
            p0 = longint'($signed(m0)) * longint'(a);
            p1 = longint'($signed(m1)) * longint'(b);
            p2 = longint'($signed(m2)) * longint'(c);
            e0 = p0;
            e1 = p1;
            e2 = p2;
            return (e0 + e1 + e2) >>> 16;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] x);
            logic [63:0] res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0) begin
                if (x >= res + bt) begin
                    x = x - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        endfunction

        function t_unit3 unit_normal(logic signed [65:0] n [3]);
            logic [63:0] mag [3];
            logic [63:0] mx, l2, r, q;
            t_unit3 u;
            mx = 0;
            l2 = 0;
            u = '0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
                if (mag[i] > mx) mx = mag[i];
            end
            if (mx == 0) return u;
            while (mx >= (64'd1 << 31)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (mx < (64'd1 << 30)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            for (int i = 0; i < 3; i++) l2 = l2 + mag[i] * mag[i];
            r = floor_sqrt(l2);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 64'd16384 + r / 2) / r;
                u[i] = n[i] < 0 ? 16'(-q) : 16'(q);
            end
            return u;
        endfunction

        function void note_input(t_in w);
            t_out o;
            int unsigned slot, ns, base;
            logic signed [65:0] n [3];
            logic signed [65:0] v, tr;
            t_unit3 u;
            logic signed [31:0] pos [3];
            slot = w.slot_or_address;
            if (w.kind == 1'b0) begin
                if (slot < POS_WORDS) pos_mem[slot] = w.word_value;
                else if (slot - POS_WORDS < NRM_WORDS) nrm_mem[slot - POS_WORDS] = w.word_value;
                return;
            end
            o = '0;
            if (slot > MAX_POS_SLOT) begin
                add_expected(o);
                return;
            end
            if (nrm_en) begin
                ns = slot >= NRM_SLOT_OFFSET ? slot - NRM_SLOT_OFFSET : slot;
                if (ns > MAX_NRM_SLOT) begin
                    add_expected(o);
                    return;
                end
                for (int i = 0; i < 3; i++) begin
                    base = ns * 3 + i * 3;
                    n[i] = dot_floor(nrm_mem[base], nrm_mem[base+1], nrm_mem[base+2],
                                     w.nrm_x, w.nrm_y, w.nrm_z);
                end
                u = unit_normal(n);
                o.out_nx = u[0];
                o.out_ny = u[1];
                o.out_nz = u[2];
            end
            o.ok = 1'b1;
            pos[0] = w.pos_x;
            pos[1] = w.pos_y;
            pos[2] = w.pos_z;
            for (int i = 0; i < 3; i++) begin
                base = slot * 4 + i * 4;
                tr = $signed(pos_mem[base+3]);
                v = dot_floor(pos_mem[base], pos_mem[base+1], pos_mem[base+2],
                              pos[0], pos[1], pos[2]) + tr;
                if (v > 66'sd2147483647) begin
                    v = 66'sd2147483647;
                    o.ok = 1'b0;
                end else if (v < -66'sd2147483648) begin
                    v = -66'sd2147483648;
                    o.ok = 1'b0;
                end
                if (i == 0) o.out_x = v[31:0];
                else if (i == 1) o.out_y = v[31:0];
                else o.out_z = v[31:0];
            end
            o.out_color = col_en ? w.color_rgba : COLOR_WHITE;
            o.out_u = tex_en ? w.tex_u : '0;
            o.out_v = tex_en ? w.tex_v : '0;
            add_expected(o);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp x %h y %h z %h n %h %h %h c %h u %h v %h ok %b",
                        e.out_x, e.out_y, e.out_z, e.out_nx, e.out_ny, e.out_nz,
                        e.out_color, e.out_u, e.out_v, e.ok);
                    $display("          got x %h y %h z %h n %h %h %h c %h u %h v %h ok %b",
                        got.out_x, got.out_y, got.out_z, got.out_nx, got.out_ny, got.out_nz,
                        got.out_color, got.out_u, got.out_v, got.ok);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_addr;
    logic       i_cfg_wdata;

    vertex_scoreboard sb;
    int gap_pct;
    int stall_pct;

    vertex_transform_normalize dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge i_clk) i_out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h7F_FFFF)) - 32'h40_0000;
        endcase
    endfunction

    task automatic send_word(t_in w);
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = w;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        sb.note_input(w);
    endtask

    function automatic t_in rand_vertex(int unsigned slot);
        t_in w;
        w.kind = 1'b1;
        w.slot_or_address = 9'(slot);
        w.word_value = $urandom;
        w.pos_x = rand_coord();
        w.pos_y = rand_coord();
        w.pos_z = rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            w.nrm_x = '0;
            w.nrm_y = '0;
            w.nrm_z = '0;
        end else begin
            w.nrm_x = rand_coord();
            w.nrm_y = rand_coord();
            w.nrm_z = rand_coord();
        end
        w.color_rgba = $urandom;
        w.tex_u = $urandom;
        w.tex_v = $urandom;
        return w;
    endfunction

    task automatic send_load(int unsigned addr, logic [31:0] val);
        t_in w;
        w = rand_vertex(0);
        w.kind = 1'b0;
        w.slot_or_address = 9'(addr);
        w.word_value = val;
        send_word(w);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (NRM_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, bit val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        sb.set_cfg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int unsigned slot;
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 9) == 0) send_load($urandom_range(352, 511), $urandom);
            else send_load($urandom_range(0, 351), rand_word());
        end else begin
            case ($urandom_range(0, 19))
                0: slot = $urandom_range(62, 511);
                1: slot = $urandom_range(30, 31);
                default: begin
                    slot = $urandom_range(0, 29);
                    if ($urandom_range(0, 1)) slot += NRM_SLOT_OFFSET;
                end
            endcase
            send_word(rand_vertex(slot));
        end
    endtask

    initial begin
        t_in w;
        sb = new();
        gap_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_NORMALS;
        i_cfg_wdata = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int a = 0; a < POS_WORDS + NRM_WORDS; a++) send_load(a, rand_word());

        write_cfg(CFG_NORMALS, 1'b1);
        write_cfg(CFG_COLOR, 1'b1);
        write_cfg(CFG_TEXCOORD, 1'b1);
        // overflow on slot 0 and saturating both ways
        send_load(0, 32'h7FFF_FFFF);
        w = rand_vertex(0);
        w.pos_x = 32'h7FFF_FFFF;
        send_word(w);
        w.pos_x = 32'h8000_0000;
        send_word(w);
        // zero normal, extremes of the pass-through fields
        w = rand_vertex(61);
        w.nrm_x = '0;
        w.nrm_y = '0;
        w.nrm_z = '0;
        w.color_rgba = '1;
        w.tex_u = 32'h8000_0000;
        w.tex_v = 32'h7FFF_FFFF;
        send_word(w);
        w.color_rgba = '0;
        w.tex_u = '0;
        w.tex_v = '0;
        w.slot_or_address = 9'd32;
        send_word(w);
        send_word(rand_vertex(62));
        send_word(rand_vertex(511));
        send_word(rand_vertex(30));
        send_word(rand_vertex(31));
        send_load(351, 32'h8000_0000);
        send_load(352, $urandom);
        send_load(511, $urandom);
        send_word(rand_vertex(61));
        send_word(rand_vertex(29));
        w = rand_vertex(5);
        w.nrm_x = 32'h7FFF_FFFF;
        w.nrm_y = 32'h8000_0000;
        w.nrm_z = 32'h7FFF_FFFF;
        send_word(w);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(CFG_NORMALS, ph[0]);
            write_cfg(CFG_COLOR, ph[1]);
            write_cfg(CFG_TEXCOORD, ph[2]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; end
                default: begin gap_pct = 33; stall_pct = 33; end
            endcase
            for (int k = 0; k < 24; k++) begin
                random_word();
                // hold off until the pipe is empty once per phase
                if (k == 12) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (sb.expected_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        stall_pct = 0;
        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/vtn_pkg.sv
sv/vtn_store.sv
sv/vtn_xform.sv
sv/vtn_norm.sv
sv/vertex_transform_normalize.sv
dv/tb.sv
